// File: hdl/timer_event_scheduler_top_assert.svh
// Assertion macros for the timer event scheduler; they clock on i_clk and reset on i_rst_n.
`ifndef TIMER_EVENT_SCHEDULER_TOP_ASSERT_SVH
`define TIMER_EVENT_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TES_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tes: property failed");
`define TES_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("tes: forbidden condition");
`else
`define TES_ASSERT(lbl, prop)
`define TES_NEVER(lbl, expr)
`endif
`endif

// File: hdl/tes_pkg.sv
package tes_pkg;

    localparam int NUM_SLOTS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_FIRE        = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_ATTACH = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  slot;
        logic [15:0] delay_ticks;
        logic [15:0] period;
    } t_item;

    typedef struct packed {
        logic [2:0] fired_slot;
        logic       last;
    } t_result;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_ATTACH = 1'b1
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [2:0]  slot;
        logic [15:0] delay;
        logic [15:0] period;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qport;

endpackage

// File: hdl/tes_front.sv
`include "timer_event_scheduler_top_assert.svh"

module tes_front import tes_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_item  i_item,
    input  logic   i_pop,
    output logic   o_busy,
    output t_qport o_q
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_op           r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic          keep;
    logic          push;
    t_op           op_in;

    always_comb begin
        keep = (i_item.cmd == CMD_TICK) || (32'(i_item.slot) < 32'(NUM_SLOTS));
        push = i_start && !o_busy && keep;
        op_in.kind   = (i_item.cmd == CMD_ATTACH) ? OP_ATTACH : OP_TICK;
        op_in.slot   = i_item.slot;
        op_in.delay  = i_item.delay_ticks;
        op_in.period = i_item.period;
        n_wp = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    end

    assign o_busy   = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_q.valid = (r_cnt != '0);
    assign o_q.op    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= op_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `TES_NEVER(a_q_overflow, r_cnt > CW'(QUEUE_DEPTH))
    `TES_ASSERT(a_pop_nonempty, i_pop |-> r_cnt != '0)
    `TES_ASSERT(a_cnt_step, push && !i_pop |=> r_cnt == $past(r_cnt) + 1'b1)

endmodule

// File: hdl/tes_back.sv
`include "timer_event_scheduler_top_assert.svh"

module tes_back import tes_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qport  i_q,
    output logic    o_pop,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW = $clog2(NUM_SLOTS + 1);
    localparam int LW = $clog2(MAX_FIRE + 1);
    localparam int EW = (MAX_FIRE > 1) ? $clog2(MAX_FIRE) : 1;
    localparam int CNTW = COUNT_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state              r_state;
    logic [CNTW-1:0]     r_count;
    logic [NUM_SLOTS-1:0] r_armed;
    logic [CNTW-1:0]     r_due_mem [NUM_SLOTS];
    logic [CNTW-1:0]     r_per_mem [NUM_SLOTS];
    logic [CNTW-1:0]     r_due_q;
    logic [CNTW-1:0]     r_per_q;
    logic [IW-1:0]       r_iss;
    logic                r_pv;
    logic [SW-1:0]       r_pslot;
    logic [SW-1:0]       r_ent_slot [MAX_FIRE];
    logic [CNTW-1:0]     r_ent_diff [MAX_FIRE];
    logic [CNTW-1:0]     r_ent_per  [MAX_FIRE];
    logic [SW-1:0]       n_ent_slot [MAX_FIRE];
    logic [CNTW-1:0]     n_ent_diff [MAX_FIRE];
    logic [CNTW-1:0]     n_ent_per  [MAX_FIRE];
    logic [LW-1:0]       r_lcnt;
    logic [LW-1:0]       n_lcnt;
    logic [EW-1:0]       r_eidx;
    logic                r_strobe;
    t_result             r_res;

    logic                is_attach;
    logic [SW+2:0]       slot_ext;
    logic [SW-1:0]       att_addr;
    logic [SW-1:0]       rd_addr;
    logic [CNTW-1:0]     diff_new;
    logic                due_new;
    logic [MAX_FIRE-1:0] keep;
    logic                ins;
    logic [SW-1:0]       emit_slot;
    logic [CNTW-1:0]     emit_diff;
    logic [CNTW-1:0]     emit_per;
    logic                emit_last;
    logic                emit_go;
    logic [CNTW-1:0]     new_due;
    logic                due_we;
    logic                per_we;
    logic [SW-1:0]       wr_addr;
    logic [CNTW-1:0]     wr_due;

    always_comb begin
        o_pop     = (r_state == S_IDLE) && i_q.valid;
        is_attach = (i_q.op.kind == OP_ATTACH);
        slot_ext  = (SW + 3)'(i_q.op.slot);
        att_addr  = slot_ext[SW-1:0];
        rd_addr   = r_iss[SW-1:0];

        diff_new = r_due_q - r_count;
        due_new  = r_pv && r_armed[r_pslot] && (diff_new[CNTW-1] || (diff_new == '0));
        for (int j = 0; j < MAX_FIRE; j++) begin
            keep[j] = (LW'(j) < r_lcnt) && ($signed(r_ent_diff[j]) <= $signed(diff_new));
        end
        ins    = due_new && !keep[MAX_FIRE-1];
        n_lcnt = (r_lcnt == LW'(MAX_FIRE)) ? r_lcnt : r_lcnt + 1'b1;

        n_ent_slot[0] = keep[0] ? r_ent_slot[0] : r_pslot;
        n_ent_diff[0] = keep[0] ? r_ent_diff[0] : diff_new;
        n_ent_per[0]  = keep[0] ? r_ent_per[0]  : r_per_q;
        for (int j = 1; j < MAX_FIRE; j++) begin
            if (keep[j]) begin
                n_ent_slot[j] = r_ent_slot[j];
                n_ent_diff[j] = r_ent_diff[j];
                n_ent_per[j]  = r_ent_per[j];
            end else if (keep[j-1]) begin
                n_ent_slot[j] = r_pslot;
                n_ent_diff[j] = diff_new;
                n_ent_per[j]  = r_per_q;
            end else begin
                n_ent_slot[j] = r_ent_slot[j-1];
                n_ent_diff[j] = r_ent_diff[j-1];
                n_ent_per[j]  = r_ent_per[j-1];
            end
        end

        emit_slot = r_ent_slot[r_eidx];
        emit_diff = r_ent_diff[r_eidx];
        emit_per  = r_ent_per[r_eidx];
        emit_last = ((LW'(r_eidx) + 1'b1) == r_lcnt);
        emit_go   = (r_state == S_EMIT) && (r_lcnt != '0);
        new_due   = r_count + emit_diff + emit_per;

        due_we  = (o_pop && is_attach) || (emit_go && (emit_per != '0));
        per_we  = o_pop && is_attach;
        wr_addr = (r_state == S_EMIT) ? emit_slot : att_addr;
        wr_due  = (r_state == S_EMIT) ? new_due : r_count + CNTW'(i_q.op.delay);
    end

    always_ff @(posedge i_clk) begin
        if (due_we) begin
            r_due_mem[wr_addr] <= wr_due;
        end
        r_due_q <= r_due_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (per_we) begin
            r_per_mem[wr_addr] <= CNTW'(i_q.op.period);
        end
        r_per_q <= r_per_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && ins) begin
            r_ent_slot <= n_ent_slot;
            r_ent_diff <= n_ent_diff;
            r_ent_per  <= n_ent_per;
        end
        if (emit_go) begin
            r_res.fired_slot <= 3'(emit_slot);
            r_res.last       <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_armed  <= '0;
            r_iss    <= '0;
            r_pv     <= 1'b0;
            r_pslot  <= '0;
            r_lcnt   <= '0;
            r_eidx   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_pv     <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (is_attach) begin
                            r_armed[att_addr] <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                            r_iss   <= '0;
                            r_lcnt  <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_iss != IW'(NUM_SLOTS)) begin
                        r_iss   <= r_iss + 1'b1;
                        r_pv    <= 1'b1;
                        r_pslot <= r_iss[SW-1:0];
                    end else if (!r_pv) begin
                        r_eidx  <= '0;
                        r_state <= S_EMIT;
                    end
                    if (ins) begin
                        r_lcnt <= n_lcnt;
                    end
                end
                S_EMIT: begin
                    if (r_lcnt == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_strobe <= 1'b1;
                        if (emit_per == '0) begin
                            r_armed[emit_slot] <= 1'b0;
                        end
                        r_eidx <= r_eidx + 1'b1;
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `TES_ASSERT(a_last_ends_tick, r_strobe && r_res.last |-> r_state == S_IDLE)
    `TES_NEVER(a_list_overflow, r_lcnt > LW'(MAX_FIRE))
    `TES_ASSERT(a_pop_only_idle, o_pop |-> r_state == S_IDLE && i_q.valid)

endmodule

// File: hdl/timer_event_scheduler_top.sv
// Timer event scheduler: a tick count with NUM_SLOTS event slots, each armed with
// a due time and a reload period. An attach transfer arms a slot; a tick transfer advances the
// count and then reports every due slot, most overdue first, one o_strobe pulse per firing,
// with last set on the final one. A tick with nothing due reports nothing. Results cannot be
// held off, so sample o_result whenever o_strobe is high. A two-entry queue sits behind the
// input, and busy rises only when it is full. An attach is applied in the idle state of the
// execution side; a tick runs a scan that reads the due-time and period memories one slot per
// cycle and sorts due slots into an eight-entry list, then reports up to eight firings from it.
module timer_event_scheduler_top import tes_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    t_qport q;
    logic   pop;

    tes_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_busy  (busy),
        .o_q     (q)
    );

    tes_back #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q      (q),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tes_pkg::*;

    localparam int NUM_TICK_SLOTS = NUM_SLOTS_DEF;
    localparam int ITEM_TARGET    = 360;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    t_item   cmd_item = '0;
    logic    busy;
    logic    strobe;
    t_result firing;

    t_item   cmd_q[$];
    t_result firing_q[$];

    logic [15:0] tick_now;
    logic [15:0] due_at [NUM_TICK_SLOTS];
    logic [15:0] reload_by [NUM_TICK_SLOTS];
    bit          armed_flag [NUM_TICK_SLOTS];

    int sent_cnt = 0;
    int fail_cnt = 0;
    int stall_cnt = 0;

    timer_event_scheduler_top DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .i_item   (cmd_item),
        .busy     (busy),
        .o_strobe (strobe),
        .o_result (firing)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic add_attach(input int slot_no, input int delay_val, input int period_val);
        t_item it;
        it.cmd         = CMD_ATTACH;
        it.slot        = 3'(slot_no);
        it.delay_ticks = 16'(delay_val);
        it.period      = 16'(period_val);
        cmd_q.push_back(it);
    endtask

    task automatic add_tick();
        t_item it;
        it.cmd         = CMD_TICK;
        it.slot        = 3'($urandom_range(0, 7));
        it.delay_ticks = 16'($urandom_range(0, 65535));
        it.period      = 16'($urandom_range(0, 65535));
        cmd_q.push_back(it);
    endtask

    // Update the slot table for one transfer and queue the firings it causes.
    task automatic schedule_item(input t_item it);
        logic signed [15:0] lag [NUM_TICK_SLOTS];
        bit                 pend [NUM_TICK_SLOTS];
        int                 order [$];
        int                 best;
        int                 s;
        t_result            r;
        if (it.cmd == CMD_ATTACH) begin
            if (int'(it.slot) < NUM_TICK_SLOTS) begin
                due_at[it.slot]     = tick_now + it.delay_ticks;
                reload_by[it.slot]  = it.period;
                armed_flag[it.slot] = 1'b1;
            end
        end else begin
            tick_now = tick_now + 16'd1;
            for (int i = 0; i < NUM_TICK_SLOTS; i++) begin
                lag[i]  = due_at[i] - tick_now;
                pend[i] = armed_flag[i] && (lag[i] <= 0);
            end
            while (order.size() < MAX_FIRE) begin
                best = -1;
                for (int i = 0; i < NUM_TICK_SLOTS; i++) begin
                    if (pend[i] && (best < 0 || lag[i] < lag[best])) begin
                        best = i;
                    end
                end
                if (best < 0) break;
                pend[best] = 1'b0;
                order.push_back(best);
            end
            for (int k = 0; k < order.size(); k++) begin
                s = order[k];
                if (reload_by[s] != 16'd0) begin
                    due_at[s] = due_at[s] + reload_by[s];
                end else begin
                    armed_flag[s] = 1'b0;
                end
                r.fired_slot = 3'(s);
                r.last       = (k == order.size() - 1);
                firing_q.push_back(r);
            end
        end
    endtask

    initial begin : stim_p
        int dly;
        int per;
        int pick;
        tick_now = '0;
        for (int i = 0; i < NUM_TICK_SLOTS; i++) begin
            due_at[i]     = '0;
            reload_by[i]  = '0;
            armed_flag[i] = 1'b0;
        end

        add_tick();
        add_attach(0, 0, 0);
        add_attach(7, 16'hFFFF, 16'hFFFF);
        add_attach(3, 16'h8001, 1);
        add_attach(5, 16'h7FFF, 0);
        add_attach(1, 0, 0);
        add_tick();
        add_tick();
        add_attach(3, 2, 0);
        add_attach(7, 1, 3);
        add_attach(5, 3, 16'h8000);
        add_tick();
        add_tick();
        add_tick();
        add_tick();
        add_attach(2, 0, 0);
        add_attach(4, 0, 0);
        add_attach(6, 0, 0);
        add_attach(0, 0, 16'h8000);
        add_tick();
        add_tick();
        add_attach(5, 16'h7FFF, 16'h7FFF);
        add_tick();
        add_tick();

        while (cmd_q.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 75) begin
                repeat ($urandom_range(1, 3)) begin
                    pick = $urandom_range(0, 9);
                    dly  = (pick == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
                    pick = $urandom_range(0, 9);
                    if (pick < 3) per = 0;
                    else if (pick < 9) per = $urandom_range(1, 10);
                    else per = $urandom_range(0, 65535);
                    add_attach($urandom_range(0, 7), dly, per);
                end
                repeat ($urandom_range(1, 8)) add_tick();
            end else if ($urandom_range(0, 1) == 0) begin
                add_tick();
            end else begin
                add_attach($urandom_range(0, 7), $urandom_range(0, 65535),
                           $urandom_range(0, 65535));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() != 0 || firing_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    always @(posedge clk) begin : drive_p
        bit idle;
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                schedule_item(cmd_q.pop_front());
                sent_cnt++;
            end
            idle = ($urandom_range(0, 99) < 17) && !(sent_cnt >= 140 && sent_cnt < 220);
            if (start && busy) begin
                // hold the pending transfer
            end else if (cmd_q.size() != 0 && !idle) begin
                start    <= 1'b1;
                cmd_item <= cmd_q[0];
            end else begin
                start    <= 1'b0;
                cmd_item <= t_item'(36'({$urandom, $urandom}));
            end
        end
    end

    always @(posedge clk) begin : check_p
        t_result want;
        if (rst_n && strobe) begin
            if (firing_q.size() == 0) begin
                $error("unexpected firing: fired_slot %0d last %0b",
                       firing.fired_slot, firing.last);
                fail_cnt++;
            end else begin
                want = firing_q.pop_front();
                if (firing.fired_slot !== want.fired_slot) begin
                    $error("fired_slot: expected %0d, actual %0d",
                           want.fired_slot, firing.fired_slot);
                    fail_cnt++;
                end
                if (firing.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, firing.last);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || strobe || (cmd_q.size() == 0 && firing_q.size() == 0)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tes_pkg.sv
hdl/tes_front.sv
hdl/tes_back.sv
hdl/timer_event_scheduler_top.sv
tb/sv/testbench.sv
